[sv/mkd_pkg.sv]
package mkd_pkg;

    // configuration register widths
    localparam int UNIT_W  = 17;
    localparam int UNITS_W = 4;
    localparam int LIMIT_W = UNIT_W + UNITS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = UNIT_W;

    // timing counters
    localparam int TICK_W = 32;

    // result payload widths
    localparam int COUNT_W   = 3;
    localparam int PATTERN_W = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_UNITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_UNITS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_UNITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_UNITS = 3'd4;

    // reset values
    localparam logic [UNIT_W-1:0]  UNIT_TICKS_RST  = 17'd15625;
    localparam logic [UNITS_W-1:0] DASH_UNITS_RST  = 4'd2;
    localparam logic [UNITS_W-1:0] GAP_UNITS_RST   = 4'd3;
    localparam logic [UNITS_W-1:0] SPACE_UNITS_RST = 4'd7;
    localparam logic [UNITS_W-1:0] CLEAR_UNITS_RST = 4'd8;

    typedef enum logic [1:0] {
        EV_LETTER = 2'd0,
        EV_SPACE  = 2'd1,
        EV_CLEAR  = 2'd2
    } event_kind_t;

    // thresholds in ticks, from the limits block to the timing core
    typedef struct packed {
        logic [LIMIT_W-1:0] dash;
        logic [LIMIT_W-1:0] gap;
        logic [LIMIT_W-1:0] space;
        logic [LIMIT_W-1:0] clear;
    } limits_t;

    typedef struct packed {
        event_kind_t          kind;
        logic [COUNT_W-1:0]   count;
        logic [PATTERN_W-1:0] pattern;
    } event_t;

endpackage

[sv/mkd_ifs.sv]
interface mkd_key_if;
    logic valid;
    logic ready;
    logic key_down;

    modport source (output valid, output key_down, input ready);
    modport sink (input valid, input key_down, output ready);
endinterface

interface mkd_evt_if import mkd_pkg::*;;
    logic                 valid;
    logic                 ready;
    event_kind_t          event_kind;
    logic [COUNT_W-1:0]   symbol_count;
    logic [PATTERN_W-1:0] symbol_pattern;

    modport source (output valid, output event_kind, output symbol_count,
                    output symbol_pattern, input ready);
    modport sink (input valid, input event_kind, input symbol_count,
                  input symbol_pattern, output ready);
endinterface

interface mkd_cfg_if import mkd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/mkd_limits.sv]
module mkd_limits import mkd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output limits_t               limits,
    output logic                  stale
);

    logic [UNIT_W-1:0]  unit_ticks_reg;
    logic [UNITS_W-1:0] dash_units_reg;
    logic [UNITS_W-1:0] gap_units_reg;
    logic [UNITS_W-1:0] space_units_reg;
    logic [UNITS_W-1:0] clear_units_reg;
    logic               stale_reg;
    limits_t            limits_reg;
    limits_t            limits_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg  <= UNIT_TICKS_RST;
            dash_units_reg  <= DASH_UNITS_RST;
            gap_units_reg   <= GAP_UNITS_RST;
            space_units_reg <= SPACE_UNITS_RST;
            clear_units_reg <= CLEAR_UNITS_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_UNIT_TICKS:  unit_ticks_reg  <= wr_data;
                REG_DASH_UNITS:  dash_units_reg  <= wr_data[UNITS_W-1:0];
                REG_GAP_UNITS:   gap_units_reg   <= wr_data[UNITS_W-1:0];
                REG_SPACE_UNITS: space_units_reg <= wr_data[UNITS_W-1:0];
                REG_CLEAR_UNITS: clear_units_reg <= wr_data[UNITS_W-1:0];
                default: ;
            endcase
        end
    end

    // one small multiply per threshold
    always_comb
    begin
        limits_next.dash  = LIMIT_W'(dash_units_reg)  * LIMIT_W'(unit_ticks_reg);
        limits_next.gap   = LIMIT_W'(gap_units_reg)   * LIMIT_W'(unit_ticks_reg);
        limits_next.space = LIMIT_W'(space_units_reg) * LIMIT_W'(unit_ticks_reg);
        limits_next.clear = LIMIT_W'(clear_units_reg) * LIMIT_W'(unit_ticks_reg);
    end

    always_ff @(posedge clk)
    begin
        limits_reg <= limits_next;
    end

    // products are registered and lag the registers; stale marks them out of date after a write or reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stale_reg <= 1'b1;
        else
            stale_reg <= wr_en;
    end

    assign limits = limits_reg;
    assign stale  = stale_reg;

endmodule

[sv/mkd_core.sv]
module mkd_core import mkd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  logic    key_down,
    input  limits_t limits,
    output logic    res_valid,
    output event_t  res
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W = $clog2(MAX_SYMBOLS);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SYMBOLS);

    logic                   last_key_reg, last_key_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [TICK_W-1:0]      idle_reg, idle_next;
    logic [MAX_SYMBOLS-1:0] sym_reg, sym_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pending_reg, pending_next;
    logic                   space_reg, space_next;

    logic              tick_max;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] idle_inc;
    logic              down_edge, up_edge, gap_wait;
    logic              is_dash, is_dot;
    logic              ge_gap, ge_space, ge_clear, clear_zero;
    logic              counters_cleared, clear_hit;

    // idle_reg counts ticks since the last key edge or emitted event
    assign tick_max = &tick_reg;
    assign tick_inc = tick_max ? tick_reg : tick_reg + TICK_W'(1);
    assign idle_inc = tick_max ? idle_reg : idle_reg + TICK_W'(1);

    assign down_edge = key_down && !last_key_reg;
    assign up_edge   = !key_down && last_key_reg;
    assign gap_wait  = !key_down && !last_key_reg && pending_reg;

    assign is_dash    = tick_inc > TICK_W'(limits.dash);
    assign is_dot     = tick_inc < TICK_W'(limits.dash);
    assign ge_gap     = idle_inc >= TICK_W'(limits.gap);
    assign ge_space   = idle_inc >= TICK_W'(limits.space);
    assign ge_clear   = idle_inc >= TICK_W'(limits.clear);
    assign clear_zero = (limits.clear == '0);

    always_comb
    begin
        last_key_next    = key_down;
        tick_next        = tick_inc;
        idle_next        = idle_inc;
        sym_next         = sym_reg;
        cnt_next         = cnt_reg;
        pending_next     = pending_reg;
        space_next       = space_reg;
        res_valid        = 1'b0;
        res.kind         = EV_LETTER;
        res.count        = '0;
        res.pattern      = '0;
        counters_cleared = 1'b0;

        if (down_edge)
        begin
            tick_next        = '0;
            idle_next        = '0;
            counters_cleared = 1'b1;
        end
        else if (up_edge)
        begin
            idle_next        = '0;
            counters_cleared = 1'b1;
            if (is_dash || is_dot)
            begin
                pending_next = 1'b1;
                if (cnt_reg >= CNT_FULL)
                begin
                    sym_next = {is_dash, sym_reg[MAX_SYMBOLS-1:1]};
                    cnt_next = CNT_FULL;
                end
                else
                begin
                    sym_next[cnt_reg[IDX_W-1:0]] = is_dash;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
        end
        else if (gap_wait)
        begin
            if (ge_gap)
            begin
                res_valid        = 1'b1;
                res.kind         = EV_LETTER;
                res.count        = cnt_reg[COUNT_W-1:0];
                res.pattern      = sym_reg[PATTERN_W-1:0];
                sym_next         = '0;
                cnt_next         = '0;
                tick_next        = '0;
                idle_next        = '0;
                pending_next     = 1'b0;
                space_next       = 1'b0;
                counters_cleared = 1'b1;
            end
        end
        else if (ge_space && !space_reg)
        begin
            res_valid        = 1'b1;
            res.kind         = EV_SPACE;
            tick_next        = '0;
            idle_next        = '0;
            space_next       = 1'b1;
            counters_cleared = 1'b1;
        end

        // clear sees the counters as the rule above left them
        clear_hit = counters_cleared ? clear_zero : ge_clear;
        if (clear_hit && space_next)
        begin
            res_valid    = 1'b1;
            res.kind     = EV_CLEAR;
            res.count    = '0;
            res.pattern  = '0;
            tick_next    = '0;
            idle_next    = '0;
            space_next   = 1'b0;
            pending_next = 1'b0;
        end

        if (!accept)
            res_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg <= 1'b0;
            tick_reg     <= '0;
            idle_reg     <= '0;
            sym_reg      <= '0;
            cnt_reg      <= '0;
            pending_reg  <= 1'b0;
            space_reg    <= 1'b0;
        end
        else if (accept)
        begin
            last_key_reg <= last_key_next;
            tick_reg     <= tick_next;
            idle_reg     <= idle_next;
            sym_reg      <= sym_next;
            cnt_reg      <= cnt_next;
            pending_reg  <= pending_next;
            space_reg    <= space_next;
        end
    end

endmodule

[sv/mkd_out.sv]
module mkd_out import mkd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  event_t push_data,
    input  logic   take_ready,
    output logic   out_valid,
    output event_t out_data,
    output logic   full
);

    logic   out_valid_reg;
    event_t out_reg;
    logic   skid_valid_reg;
    event_t skid_reg;
    logic   load;

    // output register is free when empty or being taken this cycle
    assign load = !out_valid_reg || take_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= skid_valid_reg ? skid_reg : push_data;
        if (!load && push)
            skid_reg <= push_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign full      = skid_valid_reg;

endmodule

[sv/morse_key_timing_decoder.sv]
// morse key timing decoder: one key sample item per clock while keys.ready is high, one result at most per item
// a result item reaches events from its key item through the result register, or through the skid stage when stalled
// throughput: one key item per cycle; keys.ready drops only while the skid stage is full
// and after reset or a configuration write, until the thresholds are recomputed
// reset: rst_n asynchronous, active low; clears timing state, result stages and restores
// the default register values
module morse_key_timing_decoder import mkd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    mkd_cfg_if.sink   cfg,
    mkd_key_if.sink   keys,
    mkd_evt_if.source events
);

    limits_t limits;
    logic    limits_stale;
    logic    key_accept;
    logic    res_valid;
    event_t  res;
    logic    out_full;
    logic    out_valid;
    event_t  out_data;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    // register file and threshold products, one multiply per threshold
    mkd_limits u_limits
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .limits   (limits),
        .stale    (limits_stale)
    );

    // the skid stage absorbs a result while the output register is stalled,
    // so a key item is taken whenever the skid is empty and the thresholds are not stale
    assign keys.ready = !out_full && !limits_stale;
    assign key_accept = keys.valid && keys.ready;

    // edge detection, tick counter, symbol store and event rules, all in one pass
    mkd_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (key_accept),
        .key_down  (keys.key_down),
        .limits    (limits),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register plus skid stage
    mkd_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .take_ready (events.ready),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .full       (out_full)
    );

    assign events.valid          = out_valid;
    assign events.event_kind     = out_data.kind;
    assign events.symbol_count   = out_data.count;
    assign events.symbol_pattern = out_data.pattern;

endmodule

[sv/mkd_checker.sv]
module mkd_checker import mkd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 ev_valid,
    input logic                 ev_ready,
    input event_kind_t          ev_kind,
    input logic [COUNT_W-1:0]   ev_count,
    input logic [PATTERN_W-1:0] ev_pattern
);

    // a stalled item stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid)
        else $error("event item withdrawn while stalled");

    // a stalled item keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> $stable(ev_kind) && $stable(ev_count)
            && $stable(ev_pattern))
        else $error("event payload changed while stalled");

    // space and clear carry no symbols
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && (ev_kind == EV_SPACE || ev_kind == EV_CLEAR)
            |-> ev_count == '0 && ev_pattern == '0)
        else $error("space or clear item with symbols");

    // no item offered while held in reset
    assert property (@(posedge clk) !rst_n |-> !ev_valid)
        else $error("event item offered during reset");

endmodule

bind morse_key_timing_decoder mkd_checker u_mkd_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (events.valid),
    .ev_ready   (events.ready),
    .ev_kind    (events.event_kind),
    .ev_count   (events.symbol_count),
    .ev_pattern (events.symbol_pattern)
);
